// ----- rtl/core/bld_pkg.sv -----
// ----------------------------------------------------------------------------
// bld_pkg
// Shared widths, codes and reset values for the banked line draw engine.
// ----------------------------------------------------------------------------
package bld_pkg;

    // Coordinate width of the endpoint fields
    localparam int COORD_BITS = 10;
    // Linear frame-buffer address width
    localparam int ADDR_BITS = 21;
    // Bank number and in-window offset widths
    localparam int BANK_BITS = 5;
    localparam int OFFSET_BITS = 16;
    // Default window size as a shift
    localparam int BANK_SHIFT_DEFAULT = 16;

    // Row stride register
    localparam int ROW_BYTES_BITS = 12;
    localparam logic [ROW_BYTES_BITS-1:0] ROW_BYTES_RESET = 12'd1024;

    // Request opcodes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

endpackage

// ----- rtl/core/bld_ifs.sv -----
// ----------------------------------------------------------------------------
// bld_ifs
// Valid/ready channels of the banked line draw engine: line requests,
// pixel writes and the row stride write port.
// ----------------------------------------------------------------------------

// Line request channel: load a line or ask for its next pixel
interface bld_req_if;
    logic             valid;
    logic             ready;
    logic             mode;
    bld_pkg::coord_t  x_start;
    bld_pkg::coord_t  y_start;
    bld_pkg::coord_t  x_end;
    bld_pkg::coord_t  y_end;
    logic [7:0]       pen_color;

    modport source (output valid, mode, x_start, y_start, x_end, y_end, pen_color,
                    input ready);
    modport sink   (input valid, mode, x_start, y_start, x_end, y_end, pen_color,
                    output ready);
endinterface

// Pixel write channel
interface bld_pix_if;
    logic                            valid;
    logic                            ready;
    logic [bld_pkg::BANK_BITS-1:0]   bank;
    logic [bld_pkg::OFFSET_BITS-1:0] offset;
    logic [7:0]                      color;
    logic                            bank_changed;
    logic                            last;

    modport source (output valid, bank, offset, color, bank_changed, last,
                    input ready);
    modport sink   (input valid, bank, offset, color, bank_changed, last,
                    output ready);
endinterface

// Row stride write channel
interface bld_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bld_pkg::ROW_BYTES_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/banked_line_draw_engine_top.sv -----
// ----------------------------------------------------------------------------
// banked_line_draw_engine_top
// Bresenham line rasterizer emitting banked frame-buffer pixel writes.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result register is not blocked. A
// load request latches two endpoints and a color; each following step
// request yields one pixel write (bank, offset, color) until max(dx,dy)+1
// pixels are out, after which steps yield nothing. A request goes through
// an input register and one stage of logic into the result register; the
// throughput of one request per cycle holds as long as the pixel sink takes a
// write every cycle, since the result register frees up in the same cycle it
// is read. Row stride is to be written on the cfg port by the user only while
// no request is in flight; the block itself does not enforce this.
module banked_line_draw_engine_top #(
    parameter int BANK_SHIFT = bld_pkg::BANK_SHIFT_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    bld_req_if.sink      req,
    bld_pix_if.source    pix,
    bld_cfg_if.sink      cfg
);

    localparam int CB = bld_pkg::COORD_BITS;
    localparam int AB = bld_pkg::ADDR_BITS;
    localparam int OB = bld_pkg::OFFSET_BITS;
    localparam int BB = bld_pkg::BANK_BITS;
    localparam int RB = bld_pkg::ROW_BYTES_BITS;
    localparam int PB = CB + RB;
    localparam logic [OB-1:0] WIN_MASK = OB'((64'd1 << BANK_SHIFT) - 64'd1);

    // Row stride register
    logic [RB-1:0] row_bytes_reg;

    // Input stage
    logic              in_valid_reg;
    logic              mode_reg;
    bld_pkg::coord_t   xs_reg, ys_reg, xe_reg, ye_reg;
    logic [7:0]        pen_reg;

    // Line state
    bld_pkg::addr_t    addr_reg, addr_next;
    logic [CB:0]       error_sum_reg, error_sum_next;
    logic [CB-1:0]     delta_major_reg, delta_major_next;
    logic [CB-1:0]     delta_minor_reg, delta_minor_next;
    logic              x_major_reg, x_major_next;
    logic              x_neg_reg, x_neg_next;
    logic              y_neg_reg, y_neg_next;
    logic [CB:0]       pixels_left_reg, pixels_left_next;
    logic [7:0]        line_color_reg, line_color_next;
    logic [BB-1:0]     prev_bank_reg, prev_bank_next;
    logic              first_pixel_reg, first_pixel_next;

    // Result stage
    logic              out_valid_reg;
    logic [BB-1:0]     bank_reg;
    logic [OB-1:0]     offset_reg;
    logic [7:0]        color_reg;
    logic              bank_changed_reg;
    logic              last_reg;

    // Handshake
    logic fire;
    logic is_load;
    logic emit;

    assign fire      = in_valid_reg && (!out_valid_reg || pix.ready);
    assign is_load   = (mode_reg == bld_pkg::MODE_LOAD);
    assign emit      = fire && !is_load && (pixels_left_reg != '0);
    assign req.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;

    assign pix.valid        = out_valid_reg;
    assign pix.bank         = bank_reg;
    assign pix.offset       = offset_reg;
    assign pix.color        = color_reg;
    assign pix.bank_changed = bank_changed_reg;
    assign pix.last         = last_reg;

    // Load setup
    logic [CB-1:0] dx, dy, x0;
    logic          ld_x_neg, ld_y_neg, ld_x_major;
    logic [PB-1:0] row_base;
    logic [PB-1:0] start_addr;

    always_comb
    begin
        dx         = (xe_reg >= xs_reg) ? xe_reg - xs_reg : xs_reg - xe_reg;
        dy         = (ye_reg >= ys_reg) ? ye_reg - ys_reg : ys_reg - ye_reg;
        ld_x_neg   = xe_reg < xs_reg;
        ld_y_neg   = ye_reg < ys_reg;
        x0         = xs_reg;
        // horizontal line runs upward from the smaller column
        if (dy == '0)
        begin
            x0       = ld_x_neg ? xe_reg : xs_reg;
            ld_x_neg = 1'b0;
        end
        ld_x_major = dx > dy;
        row_base   = PB'(ys_reg) * PB'(row_bytes_reg);
        start_addr = row_base + PB'(x0);
    end

    // Pixel step
    logic [BB-1:0] cur_bank;
    logic [AB-1:0] addr_shr;
    logic [OB-1:0] cur_offset;
    logic [CB:0]   err_sum;
    logic          minor_step;
    logic          do_col, do_row;
    logic [AB-1:0] col_term, row_term;

    always_comb
    begin
        addr_shr   = addr_reg >> BANK_SHIFT;
        cur_bank   = addr_shr[BB-1:0];
        cur_offset = addr_reg[OB-1:0] & WIN_MASK;
        err_sum    = error_sum_reg + (CB+1)'(delta_minor_reg);
        minor_step = err_sum >= (CB+1)'(delta_major_reg);
        do_col     = x_major_reg || minor_step;
        do_row     = !x_major_reg || minor_step;
        col_term   = !do_col ? '0 : (x_neg_reg ? '1 : AB'(1));
        row_term   = !do_row ? '0 :
                     (y_neg_reg ? AB'(0) - AB'(row_bytes_reg) : AB'(row_bytes_reg));
    end

    // Next line state
    always_comb
    begin
        addr_next        = addr_reg;
        error_sum_next   = error_sum_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        x_major_next     = x_major_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;
        pixels_left_next = pixels_left_reg;
        line_color_next  = line_color_reg;
        prev_bank_next   = prev_bank_reg;
        first_pixel_next = first_pixel_reg;
        if (fire && is_load)
        begin
            x_neg_next       = ld_x_neg;
            y_neg_next       = ld_y_neg;
            x_major_next     = ld_x_major;
            delta_major_next = ld_x_major ? dx : dy;
            delta_minor_next = ld_x_major ? dy : dx;
            error_sum_next   = '0;
            pixels_left_next = (CB+1)'(ld_x_major ? dx : dy) + (CB+1)'(1);
            line_color_next  = pen_reg;
            addr_next        = start_addr[AB-1:0];
            first_pixel_next = 1'b1;
        end
        else if (emit)
        begin
            prev_bank_next   = cur_bank;
            first_pixel_next = 1'b0;
            pixels_left_next = pixels_left_reg - (CB+1)'(1);
            error_sum_next   = minor_step ? err_sum - (CB+1)'(delta_major_reg) : err_sum;
            addr_next        = addr_reg + col_term + row_term;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= bld_pkg::ROW_BYTES_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            addr_reg        <= '0;
            error_sum_reg   <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            x_major_reg     <= 1'b0;
            x_neg_reg       <= 1'b0;
            y_neg_reg       <= 1'b0;
            pixels_left_reg <= '0;
            line_color_reg  <= '0;
            prev_bank_reg   <= '0;
            first_pixel_reg <= 1'b1;
        end
        else
        begin
            if (cfg.valid)
            begin
                row_bytes_reg <= cfg.data;
            end
            if (req.valid && req.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            addr_reg        <= addr_next;
            error_sum_reg   <= error_sum_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            x_major_reg     <= x_major_next;
            x_neg_reg       <= x_neg_next;
            y_neg_reg       <= y_neg_next;
            pixels_left_reg <= pixels_left_next;
            line_color_reg  <= line_color_next;
            prev_bank_reg   <= prev_bank_next;
            first_pixel_reg <= first_pixel_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg <= req.mode;
            xs_reg   <= req.x_start;
            ys_reg   <= req.y_start;
            xe_reg   <= req.x_end;
            ye_reg   <= req.y_end;
            pen_reg  <= req.pen_color;
        end
        if (emit)
        begin
            bank_reg         <= cur_bank;
            offset_reg       <= cur_offset;
            color_reg        <= line_color_reg;
            bank_changed_reg <= first_pixel_reg || (cur_bank != prev_bank_reg);
            last_reg         <= (pixels_left_reg == (CB+1)'(1));
        end
    end

`ifndef NO_ASSERTIONS
    // A held request must stall the input while the result register is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !pix.ready |-> !req.ready)
        else $error("input accepted while pipeline stalled");

    // A load restarts the error term and the first-pixel flag
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_load |=> first_pixel_reg && (error_sum_reg == '0))
        else $error("load did not reset line state");

    // Error term stays below the major delta
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (error_sum_reg < (CB+1)'(delta_major_reg)) || (error_sum_reg == '0))
        else $error("error accumulator out of range");

    // The last pixel ends the line
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit && (pixels_left_reg == (CB+1)'(1)) |=> (pixels_left_reg == '0) && pix.last)
        else $error("last pixel did not end the line");
`endif

endmodule
